/* design/quoted_string_extract_filter_top_macros.svh */
// Assertion macros for the quoted string extract filter.
`ifndef QUOTED_STRING_EXTRACT_FILTER_TOP_MACROS_SVH
`define QUOTED_STRING_EXTRACT_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define QSEF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qsef: same-cycle check failed");

// next-cycle implication
`define QSEF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qsef: next-cycle check failed");

`endif

/* design/qsef_pkg.sv */
package qsef_pkg;

	localparam int MAX_KEPT = 63;
	localparam int CNT_W    = 6;
	localparam int ADDR_W   = CNT_W + 1;
	localparam int RAM_DEPTH = 2 ** ADDR_W;
	localparam int QDEPTH   = 2;

	localparam logic [7:0] QUOTE_BYTE     = 8'h27;
	localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
	localparam logic [7:0] ESC_BYTE       = 8'h1B;
	localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
	localparam logic [7:0] LT_BYTE        = 8'h3C;
	localparam logic [7:0] GT_BYTE        = 8'h3E;
	localparam logic [7:0] HASH_BYTE      = 8'h23;
	localparam logic [7:0] AMP_BYTE       = 8'h26;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
	} emit_cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} done_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_DATA,
		BK_NL
	} bk_state_t;

endpackage

/* design/quoted_string_extract_filter_top.sv */
// Input: one byte per cycle while the buffer bank being filled is free and the command queue has room.
// A kept literal of n bytes replays as n bytes, each one a buffer read and then a send,
// the newline directly after the last byte.
// The first byte follows the closing quote through the command queue and a FETCH buffer read.
// Two buffer banks let the next literal fill while the previous one replays.
// Reset (arst_n, async, active low) clears control state; buffer RAM is not cleared.
module quoted_string_extract_filter_top
	import qsef_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);

	ram_wr_t           wr;
	logic              fq_valid;
	logic              fq_ready;
	emit_cmd_t         fq_cmd;
	logic              qb_valid;
	logic              qb_ready;
	emit_cmd_t         qb_cmd;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	done_t             done;

	qsef_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.wr        (wr),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd),
		.done      (done)
	);

	qsef_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	qsef_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	qsef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.done      (done)
	);

endmodule

/* design/qsef_ram.sv */
module qsef_ram
	import qsef_pkg::*;
(
	input  logic              clk,
	input  ram_wr_t           wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem_q [RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/qsef_cmdq.sv */
module qsef_cmdq
	import qsef_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  emit_cmd_t push_cmd,
	output logic      pop_valid,
	input  logic      pop_ready,
	output emit_cmd_t pop_cmd
);

	emit_cmd_t slot_q [QDEPTH];
	logic      wp_q;
	logic      rp_q;
	logic [1:0] count_q;
	logic      do_push;
	logic      do_pop;

	assign push_ready = (count_q != 2'(QDEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/qsef_front.sv */
module qsef_front
	import qsef_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	output ram_wr_t    wr,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output emit_cmd_t  cmd,
	input  done_t      done
);

	logic             inside_q;
	logic             bs_odd_q;
	logic             relevant_q;
	logic             special_q;
	logic [CNT_W-1:0] kept_q;
	logic             bank_q;
	logic [1:0]       busy_q;

	logic take;
	logic is_quote;
	logic is_bs;
	logic is_bad;
	logic is_spec;
	logic closing;
	logic body;
	logic room;

	assign s_tready = !busy_q[bank_q] && cmd_ready;
	assign take     = s_tvalid && s_tready;

	assign is_quote = (s_tdata == QUOTE_BYTE);
	assign is_bs    = (s_tdata == BACKSLASH_BYTE);
	assign is_bad   = (s_tdata == LT_BYTE) || (s_tdata == GT_BYTE) ||
	                  (s_tdata == HASH_BYTE) || (s_tdata == AMP_BYTE);
	assign is_spec  = s_tdata[7] || (s_tdata == ESC_BYTE);
	assign closing  = take && inside_q && is_quote && !bs_odd_q;
	assign body     = take && inside_q && !(is_quote && !bs_odd_q);
	assign room     = (kept_q != CNT_W'(MAX_KEPT));

	assign cmd_valid = closing && relevant_q && special_q;
	assign cmd.bank  = bank_q;
	assign cmd.count = kept_q;

	assign wr.en   = body && room;
	assign wr.addr = {bank_q, kept_q};
	assign wr.data = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= 1'b0;
			bs_odd_q   <= 1'b0;
			relevant_q <= 1'b1;
			special_q  <= 1'b0;
			kept_q     <= '0;
			bank_q     <= 1'b0;
			busy_q     <= 2'b00;
		end else begin
			if (done.valid) begin
				busy_q[done.bank] <= 1'b0;
			end
			if (take && !inside_q) begin
				inside_q <= is_quote;
			end
			if (closing) begin
				inside_q   <= 1'b0;
				bs_odd_q   <= 1'b0;
				relevant_q <= 1'b1;
				special_q  <= 1'b0;
				kept_q     <= '0;
				if (cmd_valid) begin
					busy_q[bank_q] <= 1'b1;
					bank_q         <= !bank_q;
				end
			end
			if (body) begin
				if (is_bs) begin
					bs_odd_q   <= !bs_odd_q;
					relevant_q <= 1'b0;
				end else if (!is_quote) begin
					bs_odd_q <= 1'b0;
				end
				if (is_bad) begin
					relevant_q <= 1'b0;
				end
				if (is_spec) begin
					special_q <= 1'b1;
				end
				if (room) begin
					kept_q <= kept_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

/* design/qsef_back.sv */
module qsef_back
	import qsef_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  emit_cmd_t         cmd,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [7:0]        rd_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output done_t             done
);

	bk_state_t        state_q;
	bk_state_t        state_d;
	logic             bank_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             last_byte;

	assign last_byte = ((idx_q + CNT_W'(1)) == cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.count == '0) ? BK_NL : BK_FETCH;
				end
			end
			BK_FETCH: state_d = BK_DATA;
			BK_DATA: begin
				if (m_tready) begin
					state_d = last_byte ? BK_NL : BK_FETCH;
				end
			end
			BK_NL: begin
				if (m_tready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready  = 1'b0;
		rd_en      = 1'b0;
		m_tvalid   = 1'b0;
		m_tdata    = rd_data;
		m_tlast    = 1'b0;
		done.valid = 1'b0;
		done.bank  = bank_q;
		case (state_q)
			BK_IDLE:  cmd_ready = 1'b1;
			BK_FETCH: rd_en = 1'b1;
			BK_DATA:  m_tvalid = 1'b1;
			BK_NL: begin
				m_tvalid   = 1'b1;
				m_tdata    = NEWLINE_BYTE;
				m_tlast    = 1'b1;
				done.valid = m_tready;
			end
			default: cmd_ready = 1'b0;
		endcase
	end

	assign rd_addr = {bank_q, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			bank_q  <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE && cmd_valid) begin
				bank_q <= cmd.bank;
				cnt_q  <= cmd.count;
				idx_q  <= '0;
			end
			if (state_q == BK_DATA && m_tready) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

endmodule

/* design/qsef_chk.sv */
`include "quoted_string_extract_filter_top_macros.svh"

module qsef_chk
	import qsef_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// a stalled request holds its payload
	`QSEF_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// the end marker is always a newline
	`QSEF_ASSERT_NOW(a_last_nl, m_tvalid && m_tlast, m_tdata == NEWLINE_BYTE)
	// kept bytes never go out back to back; the newline may follow directly
	`QSEF_ASSERT_NEXT(a_out_gap, m_tvalid && m_tready && !m_tlast, !m_tvalid || m_tlast)
	// no output right after reset release
	`QSEF_ASSERT_NEXT(a_rst_quiet, $rose(arst_n), !m_tvalid)

endmodule

bind quoted_string_extract_filter_top qsef_chk u_qsef_chk (.*);
